// File: hdl/loht_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU open-handle tracker package
// Shared sizes, the cell link type and the cell shift selects.
// ---------------------------------------------------------------------------
package loht_pkg;

   localparam int EVICT_LIMIT = 128;
   localparam int ID_WIDTH    = 16;
   localparam int LIST_CAP    = EVICT_LIMIT + 1;
   localparam int CNT_WIDTH   = $clog2(LIST_CAP + 1);
   localparam int OCC_WIDTH   = 8;
   localparam int SCAN_LEVELS = $clog2(LIST_CAP);

   // Contents of one list position.
   typedef struct packed {
      logic                valid;
      logic [ID_WIDTH-1:0] id;
   } link_type;

   // What a cell loads on an update cycle.
   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_FROM_PREV = 2'd1,
      CELL_FROM_NEXT = 2'd2
   } cell_sel_type;

   // Request kinds.
   localparam logic KIND_OPEN   = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

endpackage

// File: hdl/loht_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU tracker cell
// Holds one list position, compares it against the key and loads from
// either neighbor when told to.
// ---------------------------------------------------------------------------
module loht_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  loht_pkg::link_type            prev_link,
   input  loht_pkg::link_type            next_link,
   input  loht_pkg::cell_sel_type        sel,
   input  logic [loht_pkg::ID_WIDTH-1:0] key,
   output loht_pkg::link_type            link,
   output logic                          hit
);
   import loht_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   logic [ID_WIDTH-1:0] id_ff;
   logic [ID_WIDTH-1:0] id_in;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      case (sel)
         CELL_FROM_PREV: begin
            valid_in = prev_link.valid;
            id_in    = prev_link.id;
         end
         CELL_FROM_NEXT: begin
            valid_in = next_link.valid;
            id_in    = next_link.id;
         end
         default: begin
            valid_in = valid_ff;
            id_in    = id_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The id needs no reset; it is only looked at while valid is set.
   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign link.valid = valid_ff;
   assign link.id    = id_ff;
   assign hit        = valid_ff && (id_ff == key);

endmodule

// File: hdl/loht_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU tracker hit scan
// Log-depth prefix and suffix OR over the registered hit vector.
// ---------------------------------------------------------------------------
module loht_scan (
   input  logic [loht_pkg::LIST_CAP-1:0] hits,
   output logic [loht_pkg::LIST_CAP-1:0] at_or_before,
   output logic [loht_pkg::LIST_CAP-1:0] at_or_after
);
   import loht_pkg::*;

   logic [LIST_CAP-1:0] pre_lvl [SCAN_LEVELS+1];
   logic [LIST_CAP-1:0] suf_lvl [SCAN_LEVELS+1];

   // Each level doubles the span; the elements of one level are independent.
   always_comb begin
      pre_lvl[0] = hits;
      suf_lvl[0] = hits;
      for (int l = 0; l < SCAN_LEVELS; l++) begin
         for (int i = 0; i < LIST_CAP; i++) begin
            if (i >= (1 << l)) begin
               pre_lvl[l+1][i] = pre_lvl[l][i] | pre_lvl[l][i - (1 << l)];
            end else begin
               pre_lvl[l+1][i] = pre_lvl[l][i];
            end
            if (i + (1 << l) < LIST_CAP) begin
               suf_lvl[l+1][i] = suf_lvl[l][i] | suf_lvl[l][i + (1 << l)];
            end else begin
               suf_lvl[l+1][i] = suf_lvl[l][i];
            end
         end
      end
   end

   assign at_or_before = pre_lvl[SCAN_LEVELS];
   assign at_or_after  = suf_lvl[SCAN_LEVELS];

endmodule

// File: hdl/lru_open_handle_tracker_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU open-handle tracker
// Recency-ordered list of up to 129 resident ids kept in a chain of cells.
// ---------------------------------------------------------------------------
// Each request beat passes through S_IDLE and S_UPDATE: in the cycle it is
// accepted every cell compares its id against the request in parallel and the
// hit vector is registered; in S_UPDATE, once the output register is empty or
// rsp_tready is high, a prefix/suffix scan of that vector steers each cell to
// hold or to load from a neighbor, and the response is loaded into the output
// register. A new request is taken once the previous one has been written
// back, so requests do not overlap; the write-back waits while a finished
// response waits on rsp_tready. Cell 0 is the most recent entry; when 129
// entries are resident an open of a new id evicts the tail cell.
// ---------------------------------------------------------------------------
module lru_open_handle_tracker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] entry_id
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [0] was_resident, [1] evict_valid,
                                    // [17:2] evicted_id, [25:18] occupancy,
                                    // [31:26] zero
);
   import loht_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   state_type            state_ff;
   logic                 kind_ff;
   logic [ID_WIDTH-1:0]  id_ff;
   logic [LIST_CAP-1:0]  hit_ff;
   logic [CNT_WIDTH-1:0] count_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_data_ff;

   link_type             cell_link [LIST_CAP];
   cell_sel_type         cell_sel  [LIST_CAP];
   logic [LIST_CAP-1:0]  hit_now;
   logic [LIST_CAP-1:0]  at_or_before;
   logic [LIST_CAP-1:0]  at_or_after;
   link_type             head_link;
   link_type             tail_link;

   logic                 req_fire;
   logic                 update_fire;
   logic                 resident;
   logic                 list_full;
   logic                 evict;
   logic [CNT_WIDTH-1:0] count_in;
   logic [31:0]          rsp_data_in;

   assign req_tready  = (state_ff == S_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign update_fire = (state_ff == S_UPDATE) && (!rsp_valid_ff || rsp_tready);

   assign head_link.valid = 1'b1;
   assign head_link.id    = id_ff;
   assign tail_link.valid = 1'b0;
   assign tail_link.id    = '0;

   genvar gi;
   generate
      for (gi = 0; gi < LIST_CAP; gi++) begin : g_cell
         loht_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .prev_link ((gi == 0) ? head_link : cell_link[(gi == 0) ? 0 : gi - 1]),
            .next_link ((gi == LIST_CAP - 1) ? tail_link
                                             : cell_link[(gi == LIST_CAP - 1) ? gi : gi + 1]),
            .sel       (cell_sel[gi]),
            .key       (req_tdata[ID_WIDTH-1:0]),
            .link      (cell_link[gi]),
            .hit       (hit_now[gi])
         );
      end
   endgenerate

   loht_scan u_scan (
      .hits         (hit_ff),
      .at_or_before (at_or_before),
      .at_or_after  (at_or_after)
   );

   assign resident  = at_or_before[LIST_CAP-1];
   assign list_full = (count_ff == CNT_WIDTH'(LIST_CAP));
   assign evict     = (kind_ff == KIND_OPEN) && !resident && list_full;

   // A touch moves everything above the hit down one place; an insert moves
   // the whole chain; a remove pulls everything from the hit onward up.
   always_comb begin
      for (int i = 0; i < LIST_CAP; i++) begin
         cell_sel[i] = CELL_HOLD;
         if (update_fire) begin
            if (kind_ff == KIND_OPEN) begin
               if (!resident || at_or_after[i]) begin
                  cell_sel[i] = CELL_FROM_PREV;
               end
            end else if (resident && at_or_before[i]) begin
               cell_sel[i] = CELL_FROM_NEXT;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (kind_ff == KIND_OPEN) begin
         if (!resident && !list_full) begin
            count_in = count_ff + CNT_WIDTH'(1);
         end
      end else if (resident) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
      rsp_data_in        = '0;
      rsp_data_in[0]     = resident;
      rsp_data_in[1]     = evict;
      rsp_data_in[17:2]  = evict ? 16'(cell_link[LIST_CAP-1].id) : 16'd0;
      rsp_data_in[25:18] = count_in[OCC_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (update_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               if (update_fire) begin
                  count_ff <= count_in;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_tuser;
         id_ff   <= req_tdata[ID_WIDTH-1:0];
         hit_ff  <= hit_now;
      end
      if (update_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
